[src/kpc_pkg.sv]
// Shared types, key state codes and register indexes for the key press classifier.
package kpc_pkg;

  typedef logic [2:0] key_state_t;

  localparam key_state_t ST_UP      = 3'd0;
  localparam key_state_t ST_RELEASE = 3'd1;
  localparam key_state_t ST_PRESS   = 3'd2;
  localparam key_state_t ST_SHORT   = 3'd3;
  localparam key_state_t ST_LONG    = 3'd4;

  localparam int unsigned CFG_DATA_WIDTH  = 16;
  localparam int unsigned CFG_INDEX_WIDTH = 1;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEBOUNCE   = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LONG_PRESS = 1'b1;

  localparam logic [CFG_DATA_WIDTH-1:0] DEBOUNCE_RESET   = 16'd10;
  localparam logic [CFG_DATA_WIDTH-1:0] LONG_PRESS_RESET = 16'd500;

  localparam int unsigned TICK_COUNT_WIDTH = 16;

endpackage

[src/kpc_cfg.sv]
// Configuration registers: debounce time and long-press time.
module kpc_cfg #(
  parameter int unsigned TICK_COUNT_WIDTH = kpc_pkg::TICK_COUNT_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [kpc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [kpc_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata,
  output logic [TICK_COUNT_WIDTH-1:0]          debounce_ticks,
  output logic [TICK_COUNT_WIDTH-1:0]          long_press_ticks
);

  logic [TICK_COUNT_WIDTH-1:0] debounce_r;
  logic [TICK_COUNT_WIDTH-1:0] long_press_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= TICK_COUNT_WIDTH'(kpc_pkg::DEBOUNCE_RESET);
      long_press_r <= TICK_COUNT_WIDTH'(kpc_pkg::LONG_PRESS_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        kpc_pkg::CFG_DEBOUNCE:   debounce_r   <= TICK_COUNT_WIDTH'(cfg_wdata);
        kpc_pkg::CFG_LONG_PRESS: long_press_r <= TICK_COUNT_WIDTH'(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign debounce_ticks   = debounce_r;
  assign long_press_ticks = long_press_r;

endmodule

[src/kpc_classify.sv]
// Tick counter, level tracking and key state update for one sample.
module kpc_classify #(
  parameter int unsigned TICK_COUNT_WIDTH = kpc_pkg::TICK_COUNT_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         level,
  input  logic [TICK_COUNT_WIDTH-1:0]  debounce_ticks,
  input  logic [TICK_COUNT_WIDTH-1:0]  long_press_ticks,
  output kpc_pkg::key_state_t          state_nxt
);

  localparam int unsigned CW = TICK_COUNT_WIDTH + 1;

  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       count_base;
  logic [CW-1:0]       count_inc;
  logic                last_level_r;
  kpc_pkg::key_state_t state_r;
  kpc_pkg::key_state_t stable;
  logic [CW-1:0]       deb_ext, lp_ext;

  assign deb_ext = {1'b0, debounce_ticks};
  assign lp_ext  = {1'b0, long_press_ticks};

  always_comb begin
    stable     = level ? kpc_pkg::ST_LONG : kpc_pkg::ST_UP;
    count_base = (level != last_level_r) ? '0 : count_r;
    count_inc  = (&count_base) ? count_base : count_base + CW'(1);
    count_nxt  = '0;
    state_nxt  = state_r;
    if (state_r != stable) begin
      count_nxt = count_inc;
      if (count_inc > deb_ext) begin
        // past the edge tick: settled level state
        if (!level) begin
          state_nxt = kpc_pkg::ST_UP;
        end else if (count_inc >= lp_ext) begin
          state_nxt = kpc_pkg::ST_LONG;
        end else begin
          state_nxt = kpc_pkg::ST_SHORT;
        end
      end else if (count_inc == deb_ext) begin
        state_nxt = level ? kpc_pkg::ST_PRESS : kpc_pkg::ST_RELEASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      last_level_r <= 1'b0;
      state_r      <= kpc_pkg::ST_UP;
    end else if (step) begin
      count_r      <= count_nxt;
      last_level_r <= level;
      state_r      <= state_nxt;
    end
  end

endmodule

[src/key_press_classifier.sv]
// Top level of the key press classifier: input register, classifier, result register.
//
// Debounces a sampled key level and reports one of five states per sample:
// up, release edge, press edge, short hold, long hold. A tick counter restarts
// on every level change; the edge state is reported on the tick the count
// equals debounce_ticks, the held state after that, and a pressed key turns to
// long hold once the count reaches long_press_ticks. Counting stops (count held
// at zero) once up or long hold is reached. Each input beat yields exactly one
// output beat. Throughput is one beat per clock while out_stall is low. From
// input accept to output valid, the accept edge loads the input register and
// the result register loads from it once free, with the count/compare logic between
// them. A stalled result holds the result register; once the input register
// is also full, in_stall goes high. Configuration writes via cfg_we take
// effect at once and are meant to be issued while no beat is in flight.
module key_press_classifier #(
  parameter int unsigned TICK_COUNT_WIDTH = kpc_pkg::TICK_COUNT_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [kpc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [kpc_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_key_level,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           out_key_state
);

  logic [TICK_COUNT_WIDTH-1:0] debounce_ticks;
  logic [TICK_COUNT_WIDTH-1:0] long_press_ticks;

  // input register stage
  logic in_valid_r;
  logic in_level_r;
  // result register stage
  logic                out_valid_r;
  kpc_pkg::key_state_t out_state_r;
  kpc_pkg::key_state_t state_nxt;

  logic out_free;  // result register can take a beat this cycle
  logic advance;   // input register beat moves to result register
  logic in_take;   // input beat accepted

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  kpc_cfg #(
    .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
  ) u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .debounce_ticks   (debounce_ticks),
    .long_press_ticks (long_press_ticks)
  );

  // state only updates when a beat leaves the input register
  kpc_classify #(
    .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
  ) u_classify (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (advance),
    .level            (in_level_r),
    .debounce_ticks   (debounce_ticks),
    .long_press_ticks (long_press_ticks),
    .state_nxt        (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_level_r <= in_key_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state_r <= state_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_state = out_state_r;

endmodule
